@@ hw/rtl/lit_pkg.sv @@
// Shared types and constants for the LRU id tracker.
// Used by every module under hw/rtl; depends on nothing else.
package lit_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned ID_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CAP_W    = 7;

  // Register port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic REG_IDX_CAPACITY = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TOUCH  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/lit_cfg_regs.sv @@
// Register port of the LRU id tracker: holds the capacity register.
// Depends on lit_pkg.
module lit_cfg_regs import lit_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CAP_W-1:0]   capacity_o
);

  logic [CAP_W-1:0] capacity_q;
  logic [CAP_W-1:0] capacity_d;
  logic             sel_cap;

  // Byte offsets within a word are not decoded.
  assign sel_cap = (paddr[2] == REG_IDX_CAPACITY);

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && sel_cap) begin
      capacity_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign prdata     = sel_cap ? PDATA_W'(capacity_q) : '0;
  assign pready     = 1'b1;
  assign capacity_o = capacity_q;

endmodule

@@ hw/rtl/lit_ctrl.sv @@
// Controller of the LRU id tracker: sequences capture and update of one word.
// Depends on lit_pkg.
module lit_ctrl import lit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: begin
        // The result register must be empty or emptying before it is reloaded.
        cmd_o.update = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/lit_datapath.sv @@
// Datapath of the LRU id tracker: recency list, parallel compare, shift and result.
// Depends on lit_pkg.
module lit_datapath import lit_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [ID_W-1:0]     request_id_i,
  input  logic [CAP_W-1:0]    capacity_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                hit_o,
  output logic                evicted_valid_o,
  output logic [ID_W-1:0]     evicted_id_o,
  output logic                removed_found_o,
  output logic [COUNT_W-1:0]  resident_count_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Slot 0 holds the least recent id, slot count-1 the most recent.
  logic [ID_BITS-1:0] entry_q [ENTRIES];
  logic [ID_BITS-1:0] entry_d [ENTRIES];
  logic [ID_BITS-1:0] up      [ENTRIES];
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_d;

  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS-1:0] id_in;
  action_e            action_q;
  logic [ENTRIES-1:0] match_q;
  logic [ENTRIES-1:0] match_d;
  logic [ENTRIES-1:0] ge_pos;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             full;
  logic             hit_any;

  logic             res_hit;
  logic             res_ev_valid;
  logic [ID_W-1:0]  res_ev_id;
  logic             res_removed;

  logic               out_valid_q;
  logic               hit_q;
  logic               ev_valid_q;
  logic [ID_W-1:0]    ev_id_q;
  logic               removed_q;
  logic [COUNT_W-1:0] res_count_q;

  assign id_in = ID_BITS'(request_id_i);

  // Compare the incoming id against every resident slot at once.
  always_comb begin
    for (int i = 0; i < int'(ENTRIES); i++) begin
      match_d[i] = (entry_q[i] == id_in) && (CNT_W'(i) < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q     <= id_in;
      action_q <= action_e'(action_i);
      match_q  <= match_d;
    end
  end

  // ge_pos marks the matching slot and every slot above it.
  always_comb begin
    for (int i = 0; i < int'(ENTRIES); i++) begin
      ge_pos[i] = |(match_q << (ENTRIES - 1 - i));
    end
  end

  always_comb begin
    for (int i = 0; i < int'(ENTRIES) - 1; i++) begin
      up[i] = entry_q[i+1];
    end
    up[ENTRIES-1] = entry_q[ENTRIES-1];
  end

  assign hit_any = |match_q;

  always_comb begin
    cap_ext = CMP_W'(capacity_i);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign full = (CMP_W'(count_q) >= eff_cap) && (count_q != '0);

  always_comb begin
    entry_d      = entry_q;
    count_d      = count_q;
    res_hit      = hit_any;
    res_ev_valid = 1'b0;
    res_ev_id    = '0;
    res_removed  = 1'b0;
    case (action_q)
      ACT_TOUCH: begin
        if (hit_any) begin
          for (int i = 0; i < int'(ENTRIES); i++) begin
            if (ge_pos[i]) begin
              entry_d[i] = (CNT_W'(i + 1) == count_q) ? id_q : up[i];
            end
          end
        end
      end
      ACT_INSERT: begin
        if (!hit_any) begin
          if (full) begin
            // Drop the least recent slot and append at the same count.
            res_ev_valid = 1'b1;
            res_ev_id    = ID_W'(entry_q[0]);
            for (int i = 0; i < int'(ENTRIES); i++) begin
              entry_d[i] = (CNT_W'(i + 1) == count_q) ? id_q : up[i];
            end
          end else begin
            for (int i = 0; i < int'(ENTRIES); i++) begin
              if (CNT_W'(i) == count_q) begin
                entry_d[i] = id_q;
              end
            end
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ACT_REMOVE: begin
        if (hit_any) begin
          res_removed = 1'b1;
          for (int i = 0; i < int'(ENTRIES); i++) begin
            if (ge_pos[i]) begin
              entry_d[i] = up[i];
            end
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      ACT_CLEAR: begin
        res_hit = 1'b0;
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      entry_q     <= entry_d;
      hit_q       <= res_hit;
      ev_valid_q  <= res_ev_valid;
      ev_id_q     <= res_ev_id;
      removed_q   <= res_removed;
      res_count_q <= COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign evicted_valid_o  = ev_valid_q;
  assign evicted_id_o     = ev_id_q;
  assign removed_found_o  = removed_q;
  assign resident_count_o = res_count_q;

endmodule

@@ hw/rtl/lru_id_tracker.sv @@
// Top level of the LRU id tracker: register port, controller and datapath.
// Depends on lit_pkg, lit_cfg_regs, lit_ctrl and lit_datapath.
//
//   Channel   Direction  Handshake                Payload
//   in        input      in_valid_i / in_stall_o  action_i, request_id_i
//   out       output     out_valid_o / out_stall_i hit_o, evicted_valid_o, evicted_id_o,
//                                                 removed_found_o, resident_count_o
//   config    input      psel/penable/pwrite      paddr, pwdata, prdata
//
// Each word is accepted in the capture cycle, which compares the id against all slots
// in parallel and registers the match; the update state shifts the list and loads the result register.
// One word is in work at a time; a new word is accepted while the previous result waits.
// A stalled output holds the update cycle until the result register frees up.
// Reset empties the list and sets capacity to 64; slot contents need no clearing.
module lru_id_tracker import lit_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [ID_W-1:0]     request_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic                evicted_valid_o,
  output logic [ID_W-1:0]     evicted_id_o,
  output logic                removed_found_o,
  output logic [COUNT_W-1:0]  resident_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  sts_t             sts;

  lit_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  lit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lit_datapath #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .request_id_i     (request_id_i),
    .capacity_i       (capacity),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .hit_o            (hit_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_id_o     (evicted_id_o),
    .removed_found_o  (removed_found_o),
    .resident_count_o (resident_count_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lru_id_tracker: a directed table, then random words
// and batches under several capacity settings. Depends on lit_pkg and the RTL only.
module tb_top;
  import lit_pkg::*;

  localparam int unsigned SLOTS       = ENTRIES_DEF;
  localparam int unsigned RAND_WORDS  = 1900;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned POOL_SIZE   = 128;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned DRAIN_CYC   = 20;
  localparam int unsigned HOLD_CYC    = 400;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned N_DIR       = 30;
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * REG_IDX_CAPACITY);

  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    logic [ID_W-1:0]    ev_id;
    logic               removed;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    action_e          act;
    logic [ID_W-1:0]  id;
    logic [CAP_W-1:0] cap;
    logic             typed;
    result_t          exp;
  } dir_row_t;

  localparam result_t NO_RES = '0;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ACTION_W-1:0] action_i = ACT_TOUCH;
  logic [ID_W-1:0]     request_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                hit_o;
  logic                evicted_valid_o;
  logic [ID_W-1:0]     evicted_id_o;
  logic                removed_found_o;
  logic [COUNT_W-1:0]  resident_count_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Model state: index 0 of recent_ids is the least recent id.
  logic [ID_W-1:0]  recent_ids[$];
  logic [CAP_W-1:0] cap_reg = CAP_RESET;
  result_t          expected_results[$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned n_results = 0;
  int unsigned n_hits = 0;
  int unsigned n_evicts = 0;
  int unsigned n_removed = 0;
  int unsigned n_cfg = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 62;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_WORD, ACT_TOUCH,  16'h0000, 7'd0,   1'b1, '{1'b0, 1'b0, 16'h0000, 1'b0, 7'd0}},
    '{ROW_WORD, ACT_REMOVE, 16'hFFFF, 7'd0,   1'b1, '{1'b0, 1'b0, 16'h0000, 1'b0, 7'd0}},
    '{ROW_WORD, ACT_INSERT, 16'h0000, 7'd0,   1'b1, '{1'b0, 1'b0, 16'h0000, 1'b0, 7'd1}},
    '{ROW_WORD, ACT_INSERT, 16'hFFFF, 7'd0,   1'b1, '{1'b0, 1'b0, 16'h0000, 1'b0, 7'd2}},
    '{ROW_WORD, ACT_INSERT, 16'h0000, 7'd0,   1'b1, '{1'b1, 1'b0, 16'h0000, 1'b0, 7'd2}},
    '{ROW_WORD, ACT_INSERT, 16'h1234, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_TOUCH,  16'h0000, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_REMOVE, 16'hFFFF, 7'd0,   1'b0, NO_RES},
    '{ROW_CFG,  ACT_TOUCH,  16'h0000, 7'd1,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'hAAAA, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h5555, 7'd0,   1'b0, NO_RES},
    '{ROW_CFG,  ACT_TOUCH,  16'h0000, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h00FF, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_CLEAR,  16'h1234, 7'd0,   1'b1, '{1'b0, 1'b0, 16'h0000, 1'b0, 7'd0}},
    '{ROW_WORD, ACT_INSERT, 16'h0001, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h0002, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_REMOVE, 16'h0002, 7'd0,   1'b0, NO_RES},
    '{ROW_CFG,  ACT_TOUCH,  16'h0000, 7'd127, 1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h8000, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h7FFF, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_TOUCH,  16'h8000, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_CLEAR,  16'h0000, 7'd0,   1'b0, NO_RES},
    '{ROW_CFG,  ACT_TOUCH,  16'h0000, 7'd2,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h0F0F, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'hF0F0, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_INSERT, 16'h3C3C, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_TOUCH,  16'hF0F0, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_REMOVE, 16'h3C3C, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_TOUCH,  16'h3C3C, 7'd0,   1'b0, NO_RES},
    '{ROW_WORD, ACT_CLEAR,  16'hFFFF, 7'd0,   1'b0, NO_RES}
  };

  lru_id_tracker dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned eff_capacity(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > SLOTS) return SLOTS;
    return cap;
  endfunction

  // Applies one word to the recency list and returns the result it must produce.
  function automatic result_t lru_apply(input action_e act, input logic [ID_W-1:0] id);
    result_t r;
    int pos;
    r = '0;
    pos = -1;
    for (int i = 0; i < recent_ids.size() && pos < 0; i++)
      if (recent_ids[i] == id) pos = i;
    if (act != ACT_CLEAR) r.hit = (pos >= 0);
    case (act)
      ACT_TOUCH: begin
        if (pos >= 0) begin
          recent_ids.delete(pos);
          recent_ids.insert(recent_ids.size(), id);
        end
      end
      ACT_INSERT: begin
        if (pos < 0) begin
          // The full test is >= so a lowered capacity evicts only one id per insert.
          if (recent_ids.size() >= eff_capacity(cap_reg) && recent_ids.size() > 0) begin
            r.ev_valid = 1'b1;
            r.ev_id    = recent_ids[0];
            recent_ids.delete(0);
          end
          if (recent_ids.size() < SLOTS) recent_ids.insert(recent_ids.size(), id);
        end
      end
      ACT_REMOVE: begin
        if (pos >= 0) begin
          r.removed = 1'b1;
          recent_ids.delete(pos);
        end
      end
      default: begin
        recent_ids.delete();
      end
    endcase
    r.count = COUNT_W'(recent_ids.size());
    return r;
  endfunction

  task automatic report_mismatch(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected hit=%0d evict=%0d/%h removed=%0d count=%0d",
               why, want.hit, want.ev_valid, want.ev_id, want.removed, want.count,
               "  got hit=%0d evict=%0d/%h removed=%0d count=%0d",
               got.hit, got.ev_valid, got.ev_id, got.removed, got.count);
  endtask

  // Drops valid, waits for every result to come back, then lets the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Writes capacity with random upper data bits, then reads it back.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    logic [PDATA_W-1:0] wdata;
    wdata = PDATA_W'($urandom);
    wdata[CAP_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_reg = value;
    n_cfg++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CAP_W-1:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH capacity readback: expected %0d, got %0d", value,
                 prdata[CAP_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one word and holds it until accepted; typed rows carry their own expectation.
  task automatic offer_word(input action_e act, input logic [ID_W-1:0] id,
                            input logic typed, input result_t typed_res);
    result_t model_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    request_id_i <= id;
    do @(posedge clk_i); while (in_stall_o);
    model_res = lru_apply(act, id);
    expected_results.insert(expected_results.size(), typed ? typed_res : model_res);
  endtask

  always @(posedge clk_i) begin : result_side
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{hit_o, evicted_valid_o, evicted_id_o, removed_found_o, resident_count_o};
      n_results++;
      n_hits    += got.hit;
      n_evicts  += got.ev_valid;
      n_removed += got.removed;
      if (expected_results.size() == 0) report_mismatch("unexpected word", NO_RES, got);
      else begin
        if (got !== expected_results[0])
          report_mismatch("result", expected_results[0], got);
        expected_results.delete(0);
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycles,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]  id_pool [POOL_SIZE];
    logic [CAP_W-1:0] phase_caps [N_PHASES];
    logic [ID_W-1:0]  batch_ids[$];
    int unsigned      sent;
    int unsigned      phase_sent;
    int unsigned      phase_len;
    int unsigned      pool_n;
    int unsigned      k;
    int unsigned      pick;
    bit               hold_done;
    action_e          act;
    logic [ID_W-1:0]  id;

    phase_caps = '{7'd64, 7'd1, 7'd2, 7'd17, 7'd0, 7'd127, 7'd64, 7'd40};
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    sent      = 0;
    hold_done = 1'b0;
    phase_len = RAND_WORDS / N_PHASES;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        write_capacity(dir_rows[r].cap);
      end else begin
        offer_word(dir_rows[r].act, dir_rows[r].id, dir_rows[r].typed, dir_rows[r].exp);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_capacity(phase_caps[p]);
      // A pool a bit larger than the capacity gives both hits and evictions.
      pool_n = eff_capacity(cap_reg) * 3 / 2 + 2;
      if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        if (sent < RAND_WORDS / 3) begin
          send_idle_pct = 15;
          recv_idle_pct = 62;
        end else if (sent < 2 * RAND_WORDS / 3) begin
          send_idle_pct = 62;
          recv_idle_pct = 15;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (p == 0 && !hold_done && phase_sent >= 100) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(99) < 60) begin
          // A batch: touches of its ids, then inserts; now and then the inserts go missing.
          k = $urandom_range(5, 2);
          batch_ids.delete();
          repeat (k) batch_ids.insert(batch_ids.size(), id_pool[$urandom_range(pool_n - 1)]);
          foreach (batch_ids[i]) offer_word(ACT_TOUCH, batch_ids[i], 1'b0, NO_RES);
          sent += k;
          phase_sent += k;
          if ($urandom_range(3) != 0) begin
            foreach (batch_ids[i]) offer_word(ACT_INSERT, batch_ids[i], 1'b0, NO_RES);
            sent += k;
            phase_sent += k;
          end
        end else begin
          pick = $urandom_range(199);
          if (pick < 2) act = ACT_CLEAR;
          else if (pick < 100) act = ACT_INSERT;
          else if (pick < 150) act = ACT_TOUCH;
          else act = ACT_REMOVE;
          if ($urandom_range(19) == 0) id = ID_W'($urandom);
          else id = id_pool[$urandom_range(pool_n - 1)];
          offer_word(act, id, 1'b0, NO_RES);
          sent++;
          phase_sent++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("covered %0d words over %0d capacity writes and a long output hold-off;",
             n_results, n_cfg);
    $display("seen %0d hits, %0d evictions, %0d removals that found their id",
             n_hits, n_evicts, n_removed);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lit_pkg.sv
hw/rtl/lit_cfg_regs.sv
hw/rtl/lit_ctrl.sv
hw/rtl/lit_datapath.sv
hw/rtl/lru_id_tracker.sv
tb/tb_top.sv
